[sv/score_sorted_record_table_defines.svh]
// Assertion macros shared by the RTL of the score-sorted record table.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SCORE_SORTED_RECORD_TABLE_DEFINES_SVH
`define SCORE_SORTED_RECORD_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssrt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssrt next-cycle check failed");

`endif

[sv/ssrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ssrt_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int NAME_BYTES_DEF = 8;
	localparam int CNT_W_DEF      = $clog2(CAPACITY_DEF + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_FIRST  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_HEAD,
		ST_SCAN,
		ST_HEAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

[sv/ssrt_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// Command channel of the record table.
interface ssrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] name_key;
	logic [31:0] player_id;
	logic [15:0] player_latency;
	logic signed [31:0] player_score;
	logic [15:0] country_code;

	modport source (output valid, cmd, name_key, player_id, player_latency,
		player_score, country_code, input ready);
	modport sink (input valid, cmd, name_key, player_id, player_latency,
		player_score, country_code, output ready);
endinterface

// Result channel of the record table; the entry count width follows the capacity.
interface ssrt_rsp_if import ssrt_pkg::*; #(
	parameter int CNT_W = CNT_W_DEF
);
	logic             valid;
	logic             ready;
	logic             ok;
	logic [63:0]      out_name;
	logic [31:0]      out_id;
	logic [15:0]      out_latency;
	logic signed [31:0] out_score;
	logic [15:0]      out_country;
	logic [CNT_W-1:0] entry_total;
	logic             is_empty;
	logic [15:0]      mean_latency;

	modport source (output valid, ok, out_name, out_id, out_latency, out_score,
		out_country, entry_total, is_empty, mean_latency, input ready);
	modport sink (input valid, ok, out_name, out_id, out_latency, out_score,
		out_country, entry_total, is_empty, mean_latency, output ready);
endinterface
`default_nettype wire

[sv/score_sorted_record_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Score-sorted record table. The block holds up to CAPACITY player records in
// one single-port-per-direction memory (one read and one write per cycle, read
// data registered), kept in ascending order of signed score; a new record lands
// after every record of equal or lower score. One command beat is taken at a time
// and gives exactly one result beat. Insert walks the table from the tail down,
// moving each record with a higher score up one slot, one record per cycle.
// Remove and lookup sweep the whole table from the head, one record per cycle,
// comparing names; remove slides the following records down in the same sweep.
// Every command then runs a restoring divider for the mean latency, one quotient
// bit per cycle, and hands the result to the output register once that is free.
// The next command beat is taken as soon as the result sits in the output
// register, even if it has not been taken yet. No clearing pass follows reset:
// table entries beyond the count are never read.
module score_sorted_record_table import ssrt_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ssrt_req_if.sink    req,
	ssrt_rsp_if.source  rsp
);

	// Widths that follow from the parameters.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = 16 + CW;
	localparam int NW = 8 * NAME_BYTES;
	localparam int RW = NW + 96;

	// Record layout inside one memory word, from the least significant bit up.
	localparam int CTRY_LO = 0;
	localparam int SCOR_LO = 16;
	localparam int LAT_LO  = 48;
	localparam int ID_LO   = 64;
	localparam int NAME_LO = 96;

	state_t state_q, state_d;

	// The record table itself.
	logic [RW-1:0] mem [CAPACITY];
	logic [RW-1:0] rd_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [RW-1:0] mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	// Command in flight and table bookkeeping.
	cmd_t          cmd_q;
	logic [RW-1:0] rec_new_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] rd_ptr_q;
	logic          rd_more_q;
	logic          matched_q;
	logic          res_ok_q;
	logic [RW-1:0] res_rec_q;

	// Divider state.
	logic [SW-1:0] quo_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] div_cnt_q;

	// Output register.
	logic          out_valid_q;

	// Derived control terms.
	logic          accept;
	logic          full;
	logic          empty;
	logic [AW-1:0] last_idx;
	logic signed [31:0] rd_score;
	logic signed [31:0] new_score;
	logic          ins_shift;
	logic          scan_hit;
	logic          scan_last;
	logic          fin;
	logic          cnt_inc;
	logic          cnt_dec;
	logic [CW-1:0] count_d;
	logic [SW-1:0] sum_d;
	logic [15:0]   hit_lat;
	logic [CW:0]   trial;
	logic          trial_ge;
	logic          out_free;

	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign last_idx  = AW'(count_q - 1'b1);
	assign rd_score  = signed'(rd_s1[SCOR_LO +: 32]);
	assign new_score = signed'(rec_new_q[SCOR_LO +: 32]);
	assign ins_shift = rd_score > new_score;
	// Only a name sweep may match; reads made by insert or read-first never count.
	assign scan_hit  = (state_q == ST_SCAN) && rd_vld_s1 && !matched_q &&
		(rd_s1[NAME_LO +: NW] == rec_new_q[NAME_LO +: NW]);
	assign scan_last = rd_vld_s1 && (rd_idx_s1 == last_idx);
	assign hit_lat   = matched_q ? res_rec_q[LAT_LO +: 16] : rd_s1[LAT_LO +: 16];
	assign out_free  = !out_valid_q || rsp.ready;
	assign trial     = {rem_q, quo_q[SW-1]};
	assign trial_ge  = trial >= {1'b0, count_q};

	assign req.ready = (state_q == ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(req.cmd))
						CMD_INSERT: begin
							if (full) state_d = ST_DIV;
							else if (empty) state_d = ST_INS_HEAD;
							else state_d = ST_INS;
						end
						CMD_REMOVE, CMD_LOOKUP: begin
							state_d = empty ? ST_DIV : ST_SCAN;
						end
						CMD_FIRST: begin
							state_d = empty ? ST_DIV : ST_HEAD;
						end
						default: state_d = ST_DIV;
					endcase
				end
			end
			ST_INS: begin
				if (rd_vld_s1) begin
					if (!ins_shift) state_d = ST_DIV;
					else if (rd_idx_s1 == '0) state_d = ST_INS_HEAD;
				end
			end
			ST_INS_HEAD: state_d = ST_DIV;
			ST_SCAN: begin
				if (scan_last) state_d = ST_DIV;
			end
			ST_HEAD: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == CW'(SW - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory strobes and bookkeeping strobes.
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = rec_new_q;
		mem_re  = 1'b0;
		mem_ra  = rd_ptr_q[AW-1:0];
		fin     = 1'b0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// Read-first fetches the head as the command is taken.
				if (accept && cmd_t'(req.cmd) == CMD_FIRST && !empty) begin
					mem_re = 1'b1;
					mem_ra = '0;
				end
				if (accept && state_d == ST_DIV) fin = 1'b1;
			end
			ST_INS: begin
				mem_re = rd_more_q;
				if (rd_vld_s1) begin
					mem_we = 1'b1;
					mem_wa = rd_idx_s1 + 1'b1;
					if (ins_shift) begin
						mem_wd = rd_s1;
					end else begin
						fin     = 1'b1;
						cnt_inc = 1'b1;
					end
				end
			end
			ST_INS_HEAD: begin
				mem_we  = 1'b1;
				mem_wa  = '0;
				fin     = 1'b1;
				cnt_inc = 1'b1;
			end
			ST_SCAN: begin
				mem_re = rd_more_q;
				// Once the victim is found, every later record slides down one slot.
				if (rd_vld_s1 && matched_q && cmd_q == CMD_REMOVE) begin
					mem_we = 1'b1;
					mem_wa = rd_idx_s1 - 1'b1;
					mem_wd = rd_s1;
				end
				if (scan_last) begin
					fin     = 1'b1;
					cnt_dec = (cmd_q == CMD_REMOVE) && (matched_q || scan_hit);
				end
			end
			ST_HEAD: fin = 1'b1;
			ST_DIV, ST_DONE: ;
			default: ;
		endcase
	end

	always_comb begin
		count_d = count_q;
		sum_d   = sum_q;
		if (cnt_inc) begin
			count_d = count_q + 1'b1;
			sum_d   = sum_q + SW'(rec_new_q[LAT_LO +: 16]);
		end else if (cnt_dec) begin
			count_d = count_q - 1'b1;
			sum_d   = sum_q - SW'(hit_lat);
		end
	end

	// Table memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_s1 <= mem[mem_ra];
		rd_idx_s1 <= mem_ra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
			sum_q     <= '0;
			rd_more_q <= 1'b0;
			matched_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			if (accept) begin
				rd_more_q <= 1'b1;
				matched_q <= 1'b0;
			end else if (mem_re) begin
				if (state_q == ST_INS) rd_more_q <= (rd_ptr_q != '0);
				else rd_more_q <= (rd_ptr_q != CW'(last_idx));
			end
			if (scan_hit) matched_q <= 1'b1;
			if (fin) begin
				count_q   <= count_d;
				sum_q     <= sum_d;
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// Command capture, scan pointer, result record and divider datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(req.cmd);
			rec_new_q <= {req.name_key[NW-1:0], req.player_id, req.player_latency,
				req.player_score, req.country_code};
			res_ok_q  <= (cmd_t'(req.cmd) == CMD_INSERT) && !full;
			res_rec_q <= '0;
			rd_ptr_q  <= (cmd_t'(req.cmd) == CMD_INSERT) ? count_q - 1'b1 : '0;
		end else if (mem_re) begin
			if (state_q == ST_INS) rd_ptr_q <= rd_ptr_q - 1'b1;
			else rd_ptr_q <= rd_ptr_q + 1'b1;
		end
		if (scan_hit) begin
			res_ok_q  <= 1'b1;
			res_rec_q <= rd_s1;
		end
		if (state_q == ST_HEAD) begin
			res_ok_q  <= 1'b1;
			res_rec_q <= rd_s1;
		end
		if (fin) begin
			quo_q <= sum_d;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[SW-2:0], trial_ge};
			rem_q <= trial_ge ? CW'(trial - {1'b0, count_q}) : trial[CW-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp.ok           <= res_ok_q;
			rsp.out_name     <= 64'(res_rec_q[NAME_LO +: NW]);
			rsp.out_id       <= res_rec_q[ID_LO +: 32];
			rsp.out_latency  <= res_rec_q[LAT_LO +: 16];
			rsp.out_score    <= signed'(res_rec_q[SCOR_LO +: 32]);
			rsp.out_country  <= res_rec_q[CTRY_LO +: 16];
			rsp.entry_total  <= count_q;
			rsp.is_empty     <= empty;
			rsp.mean_latency <= empty ? 16'd0 : quo_q[15:0];
		end
	end

	assign rsp.valid = out_valid_q;

`include "score_sorted_record_table_defines.svh"

	`SSRT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`SSRT_ASSERT_IMP(a_empty_sum, count_q == '0, sum_q == '0)
	`SSRT_ASSERT_IMP(a_write_state, mem_we, state_q == ST_INS || state_q == ST_INS_HEAD || state_q == ST_SCAN)
	`SSRT_ASSERT_NXT(a_busy_after_take, accept, !req.ready)

endmodule
`default_nettype wire
